// ===== hdl/scmh_pkg.sv =====
package scmh_pkg;

  localparam int unsigned PIX_W   = 13;
  localparam int unsigned CRD_W   = 16;
  localparam int unsigned SCL_W   = 16;
  localparam int unsigned NRECT   = 4;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [SCL_W-1:0] SCALE_RST = SCL_W'(256);
  localparam logic [PIX_W-1:0] FB_RST    = PIX_W'(4096);

  // strip slots, emitted lowest first
  localparam int unsigned STRIP_TOP    = 0;
  localparam int unsigned STRIP_BOTTOM = 1;
  localparam int unsigned STRIP_LEFT   = 2;
  localparam int unsigned STRIP_RIGHT  = 3;

  typedef enum logic [2:0] {
    REG_OFFSET_X  = 3'd0,
    REG_OFFSET_Y  = 3'd1,
    REG_SCALE_X   = 3'd2,
    REG_SCALE_Y   = 3'd3,
    REG_FB_WIDTH  = 3'd4,
    REG_FB_HEIGHT = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [PIX_W-1:0] offset_x;
    logic signed [PIX_W-1:0] offset_y;
    logic [SCL_W-1:0]        scale_x;
    logic [SCL_W-1:0]        scale_y;
    logic [PIX_W-1:0]        fb_width;
    logic [PIX_W-1:0]        fb_height;
  } cfg_t;

  typedef struct packed {
    logic                    clip_on;
    logic signed [CRD_W-1:0] clip_x;
    logic signed [CRD_W-1:0] clip_y;
    logic [CRD_W-1:0]        clip_w;
    logic [CRD_W-1:0]        clip_h;
    logic                    hole_on;
    logic signed [CRD_W-1:0] hole_x;
    logic signed [CRD_W-1:0] hole_y;
    logic [CRD_W-1:0]        hole_w;
    logic [CRD_W-1:0]        hole_h;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] w;
    logic [PIX_W-1:0] h;
  } rect_t;

  typedef struct packed {
    rect_t [NRECT-1:0] rect;
    logic [NRECT-1:0]  mask;
    logic              sc;
  } rects_t;

  typedef struct packed {
    logic [PIX_W-1:0] rect_x;
    logic [PIX_W-1:0] rect_y;
    logic [PIX_W-1:0] rect_w;
    logic [PIX_W-1:0] rect_h;
    logic             scissor_on;
    logic             last;
  } out_t;

endpackage

// ===== hdl/scmh_chan_if.sv =====
interface scmh_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/scmh_cfg_regs.sv =====
module scmh_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scmh_pkg::PADDR_W-1:0]  paddr,
  input  logic [scmh_pkg::PDATA_W-1:0]  pwdata,
  output logic [scmh_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output scmh_pkg::cfg_t                cfg_o
);
  import scmh_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        REG_OFFSET_X:  cfg_d.offset_x  = pwdata[PIX_W-1:0];
        REG_OFFSET_Y:  cfg_d.offset_y  = pwdata[PIX_W-1:0];
        REG_SCALE_X:   cfg_d.scale_x   = pwdata[SCL_W-1:0];
        REG_SCALE_Y:   cfg_d.scale_y   = pwdata[SCL_W-1:0];
        REG_FB_WIDTH:  cfg_d.fb_width  = pwdata[PIX_W-1:0];
        REG_FB_HEIGHT: cfg_d.fb_height = pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OFFSET_X:  prdata = {{(PDATA_W-PIX_W){cfg_q.offset_x[PIX_W-1]}}, cfg_q.offset_x};
      REG_OFFSET_Y:  prdata = {{(PDATA_W-PIX_W){cfg_q.offset_y[PIX_W-1]}}, cfg_q.offset_y};
      REG_SCALE_X:   prdata = {{(PDATA_W-SCL_W){1'b0}}, cfg_q.scale_x};
      REG_SCALE_Y:   prdata = {{(PDATA_W-SCL_W){1'b0}}, cfg_q.scale_y};
      REG_FB_WIDTH:  prdata = {{(PDATA_W-PIX_W){1'b0}}, cfg_q.fb_width};
      REG_FB_HEIGHT: prdata = {{(PDATA_W-PIX_W){1'b0}}, cfg_q.fb_height};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_x  <= '0;
      cfg_q.offset_y  <= '0;
      cfg_q.scale_x   <= SCALE_RST;
      cfg_q.scale_y   <= SCALE_RST;
      cfg_q.fb_width  <= FB_RST;
      cfg_q.fb_height <= FB_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hdl/scmh_geom.sv =====
module scmh_geom #(
  parameter int unsigned COORD_FRAC_BITS = 4,
  parameter int unsigned SCALE_FRAC_BITS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scmh_pkg::cfg_t cfg_i,
  scmh_chan_if.sink      item_i,
  scmh_chan_if.source    rects_o
);
  import scmh_pkg::*;

  localparam int unsigned F     = COORD_FRAC_BITS + SCALE_FRAC_BITS;
  localparam int unsigned OFS_W = PIX_W + F;
  localparam int unsigned PRD_W = (CRD_W + 2) + (SCL_W + 1);
  localparam int unsigned EW    = ((OFS_W > PRD_W) ? OFS_W : PRD_W) + 2;
  localparam int unsigned NS    = 5;

  typedef logic signed [EW-1:0]    edge_t;
  typedef logic signed [PRD_W-1:0] prod_t;

  function automatic logic [PIX_W-1:0] pix(input edge_t v);
    return v[F+PIX_W-1:F];
  endfunction

  function automatic edge_t emax(input edge_t a, input edge_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic edge_t emin(input edge_t a, input edge_t b);
    return (a < b) ? a : b;
  endfunction

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = rects_o.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign item_i.ready  = rdy[0];
  assign rects_o.valid = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= item_i.valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: products with the scale
  logic signed [CRD_W+1:0] cxe, cye;
  logic signed [SCL_W:0]   sxs, sys;
  prod_t s1_cx0_d, s1_cx1_d, s1_hx0_d, s1_hw_d, s1_cy0_d, s1_cy1_d, s1_hy0_d, s1_hh_d;
  prod_t s1_cx0_q, s1_cx1_q, s1_hx0_q, s1_hw_q, s1_cy0_q, s1_cy1_q, s1_hy0_q, s1_hh_q;
  logic  s1_clip_q, s1_hole_q;

  always_comb begin
    sxs      = $signed({1'b0, cfg_i.scale_x});
    sys      = $signed({1'b0, cfg_i.scale_y});
    cxe      = {{2{item_i.payload.clip_x[CRD_W-1]}}, item_i.payload.clip_x}
             + {2'b00, item_i.payload.clip_w};
    cye      = {{2{item_i.payload.clip_y[CRD_W-1]}}, item_i.payload.clip_y}
             + {2'b00, item_i.payload.clip_h};
    s1_cx0_d = PRD_W'(item_i.payload.clip_x) * PRD_W'(sxs);
    s1_cx1_d = PRD_W'(cxe) * PRD_W'(sxs);
    s1_hx0_d = PRD_W'(item_i.payload.hole_x) * PRD_W'(sxs);
    s1_hw_d  = PRD_W'($signed({1'b0, item_i.payload.hole_w})) * PRD_W'(sxs);
    s1_cy0_d = PRD_W'(item_i.payload.clip_y) * PRD_W'(sys);
    s1_cy1_d = PRD_W'(cye) * PRD_W'(sys);
    s1_hy0_d = PRD_W'(item_i.payload.hole_y) * PRD_W'(sys);
    s1_hh_d  = PRD_W'($signed({1'b0, item_i.payload.hole_h})) * PRD_W'(sys);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_clip_q <= item_i.payload.clip_on;
      s1_hole_q <= item_i.payload.hole_on;
      s1_cx0_q  <= s1_cx0_d;
      s1_cx1_q  <= s1_cx1_d;
      s1_hx0_q  <= s1_hx0_d;
      s1_hw_q   <= s1_hw_d;
      s1_cy0_q  <= s1_cy0_d;
      s1_cy1_q  <= s1_cy1_d;
      s1_hy0_q  <= s1_hy0_d;
      s1_hh_q   <= s1_hh_d;
    end
  end

  // stage 2: add the offset
  logic signed [OFS_W-1:0] ofx, ofy;
  edge_t s2_cx0_d, s2_cx1_d, s2_hx0_d, s2_hx1_d, s2_cy0_d, s2_cy1_d, s2_hy0_d, s2_hy1_d;
  edge_t s2_cx0_q, s2_cx1_q, s2_hx0_q, s2_hx1_q, s2_cy0_q, s2_cy1_q, s2_hy0_q, s2_hy1_q;
  logic  s2_clip_q, s2_hole_q;

  always_comb begin
    ofx      = $signed({cfg_i.offset_x, {F{1'b0}}});
    ofy      = $signed({cfg_i.offset_y, {F{1'b0}}});
    s2_cx0_d = EW'(ofx) + EW'(s1_cx0_q);
    s2_cx1_d = EW'(ofx) + EW'(s1_cx1_q);
    s2_hx0_d = EW'(ofx) + EW'(s1_hx0_q);
    s2_hx1_d = EW'(ofx) + EW'(s1_hx0_q) + EW'(s1_hw_q);
    s2_cy0_d = EW'(ofy) + EW'(s1_cy0_q);
    s2_cy1_d = EW'(ofy) + EW'(s1_cy1_q);
    s2_hy0_d = EW'(ofy) + EW'(s1_hy0_q);
    s2_hy1_d = EW'(ofy) + EW'(s1_hy0_q) + EW'(s1_hh_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s2_clip_q <= s1_clip_q;
      s2_hole_q <= s1_hole_q;
      s2_cx0_q  <= s2_cx0_d;
      s2_cx1_q  <= s2_cx1_d;
      s2_hx0_q  <= s2_hx0_d;
      s2_hx1_q  <= s2_hx1_d;
      s2_cy0_q  <= s2_cy0_d;
      s2_cy1_q  <= s2_cy1_d;
      s2_hy0_q  <= s2_hy0_d;
      s2_hy1_q  <= s2_hy1_d;
    end
  end

  // stage 3: clamp the clip to the framebuffer
  edge_t fbx, fby;
  edge_t s3_x0_d, s3_x1_d, s3_y0_d, s3_y1_d;
  edge_t s3_x0_q, s3_x1_q, s3_y0_q, s3_y1_q, s3_hx0_q, s3_hx1_q, s3_hy0_q, s3_hy1_q;
  logic  s3_clip_q, s3_hole_q;

  always_comb begin
    fbx = EW'($signed({1'b0, cfg_i.fb_width, {F{1'b0}}}));
    fby = EW'($signed({1'b0, cfg_i.fb_height, {F{1'b0}}}));
    if (s2_clip_q) begin
      s3_x0_d = emax(s2_cx0_q, '0);
      s3_y0_d = emax(s2_cy0_q, '0);
      s3_x1_d = emin(s2_cx1_q, fbx);
      s3_y1_d = emin(s2_cy1_q, fby);
    end else begin
      s3_x0_d = '0;
      s3_y0_d = '0;
      s3_x1_d = fbx;
      s3_y1_d = fby;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s3_clip_q <= s2_clip_q;
      s3_hole_q <= s2_hole_q;
      s3_x0_q   <= s3_x0_d;
      s3_x1_q   <= s3_x1_d;
      s3_y0_q   <= s3_y0_d;
      s3_y1_q   <= s3_y1_d;
      s3_hx0_q  <= s2_hx0_q;
      s3_hx1_q  <= s2_hx1_q;
      s3_hy0_q  <= s2_hy0_q;
      s3_hy1_q  <= s2_hy1_q;
    end
  end

  // stage 4: strip edges and which strips exist
  logic              empty, mid_ok;
  edge_t             s4_tt_d, s4_bb_d, s4_mt_d, s4_mb_d, s4_ll_d, s4_rr_d;
  logic [NRECT-1:0]  s4_mask_d;
  edge_t             s4_x0_q, s4_x1_q, s4_y0_q, s4_y1_q;
  edge_t             s4_tt_q, s4_bb_q, s4_mt_q, s4_mb_q, s4_ll_q, s4_rr_q;
  logic [NRECT-1:0]  s4_mask_q;
  logic              s4_sc_q;

  always_comb begin
    empty     = s3_clip_q && ((s3_x1_q <= s3_x0_q) || (s3_y1_q <= s3_y0_q));
    s4_tt_d   = s3_hole_q ? emin(s3_hy0_q, s3_y1_q) : s3_y1_q;
    s4_bb_d   = emax(s3_hy1_q, s3_y0_q);
    s4_mt_d   = emax(s3_hy0_q, s3_y0_q);
    s4_mb_d   = emin(s3_hy1_q, s3_y1_q);
    s4_ll_d   = emin(s3_hx0_q, s3_x1_q);
    s4_rr_d   = emax(s3_hx1_q, s3_x0_q);
    mid_ok    = s4_mb_d > s4_mt_d;
    s4_mask_d = '0;
    if (!empty) begin
      if (s3_hole_q) begin
        s4_mask_d[STRIP_TOP]    = s4_tt_d > s3_y0_q;
        s4_mask_d[STRIP_BOTTOM] = s3_y1_q > s4_bb_d;
        s4_mask_d[STRIP_LEFT]   = mid_ok && (s4_ll_d > s3_x0_q);
        s4_mask_d[STRIP_RIGHT]  = mid_ok && (s3_x1_q > s4_rr_d);
      end else begin
        s4_mask_d[STRIP_TOP]    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s4_x0_q   <= s3_x0_q;
      s4_x1_q   <= s3_x1_q;
      s4_y0_q   <= s3_y0_q;
      s4_y1_q   <= s3_y1_q;
      s4_tt_q   <= s4_tt_d;
      s4_bb_q   <= s4_bb_d;
      s4_mt_q   <= s4_mt_d;
      s4_mb_q   <= s4_mb_d;
      s4_ll_q   <= s4_ll_d;
      s4_rr_q   <= s4_rr_d;
      s4_mask_q <= s4_mask_d;
      s4_sc_q   <= s3_clip_q || s3_hole_q;
    end
  end

  // stage 5: whole pixels
  rects_t s5_d, s5_q;
  edge_t  dxf, dtop, dbot, dmid, dleft, dright;

  always_comb begin
    dxf    = s4_x1_q - s4_x0_q;
    dtop   = s4_tt_q - s4_y0_q;
    dbot   = s4_y1_q - s4_bb_q;
    dmid   = s4_mb_q - s4_mt_q;
    dleft  = s4_ll_q - s4_x0_q;
    dright = s4_x1_q - s4_rr_q;
    s5_d.rect[STRIP_TOP]    = '{x: pix(s4_x0_q), y: pix(s4_y0_q), w: pix(dxf), h: pix(dtop)};
    s5_d.rect[STRIP_BOTTOM] = '{x: pix(s4_x0_q), y: pix(s4_bb_q), w: pix(dxf), h: pix(dbot)};
    s5_d.rect[STRIP_LEFT]   = '{x: pix(s4_x0_q), y: pix(s4_mt_q), w: pix(dleft), h: pix(dmid)};
    s5_d.rect[STRIP_RIGHT]  = '{x: pix(s4_rr_q), y: pix(s4_mt_q), w: pix(dright), h: pix(dmid)};
    s5_d.mask = s4_mask_q;
    s5_d.sc   = s4_sc_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) s5_q <= s5_d;
  end

  assign rects_o.payload = s5_q;

  a_no_scissor_one_rect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rects_o.valid && !rects_o.payload.sc |-> rects_o.payload.mask == NRECT'(1))
    else $error("run without clip or hole must give exactly one rectangle");

endmodule

// ===== hdl/scmh_emit.sv =====
module scmh_emit (
  input  logic        clk_i,
  input  logic        rst_ni,
  scmh_chan_if.sink   rects_i,
  scmh_chan_if.source rect_o
);
  import scmh_pkg::*;

  rects_t           hold_q;
  logic [NRECT-1:0] mask_q, mask_d, first, rest;
  logic             last, load, out_fire;
  rect_t            sel;

  assign first    = mask_q & (~mask_q + NRECT'(1));
  assign rest     = mask_q & ~first;
  assign last     = rest == '0;
  assign out_fire = rect_o.valid && rect_o.ready;
  assign load     = rects_i.valid && rects_i.ready;

  assign rect_o.valid  = |mask_q;
  assign rects_i.ready = (mask_q == '0) || (rect_o.ready && last);

  always_comb begin
    sel = '0;
    for (int k = 0; k < NRECT; k++) begin
      if (first[k]) sel = hold_q.rect[k];
    end
  end

  always_comb begin
    rect_o.payload.rect_x     = sel.x;
    rect_o.payload.rect_y     = sel.y;
    rect_o.payload.rect_w     = sel.w;
    rect_o.payload.rect_h     = sel.h;
    rect_o.payload.scissor_on = hold_q.sc;
    rect_o.payload.last       = last;
  end

  always_comb begin
    mask_d = mask_q;
    if (load) begin
      mask_d = rects_i.payload.mask;
    end else if (out_fire) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) hold_q <= rects_i.payload;
  end

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !rect_o.payload.last |=> rect_o.valid)
    else $error("run ended without a last rectangle");

  a_mask_no_growth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_q != '0 && !load |=> (mask_q & ~$past(mask_q)) == '0)
    else $error("pending strips grew without a new run");

  a_single_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && mask_q != '0 |-> out_fire && last)
    else $error("new run loaded over pending strips");

endmodule

// ===== hdl/scissor_clip_minus_hole_strips.sv =====
// Scissor rectangles for one draw run: the clip rectangle minus the hole.
// item_i carries one run (clip and hole in canvas units); rect_o gives up
// to four scissor rectangles in framebuffer pixels, top band, bottom band,
// left column, right column, with last set on the final one. A run that
// yields nothing gives no transfer on rect_o.
// Configuration (offset, scale, framebuffer size) is written over the APB
// port, register i at byte address 4*i. The user must write it only while
// no run is in flight; the block itself does not enforce this.
// An item transfer loads the first of five pipeline stages; each run
// passes all five, then the strip emitter's register, to reach rect_o.
// The pipeline takes one item per cycle while item_i.ready is high; the
// emitter sends one rectangle per cycle while rect_o is ready, and a run
// gives 0 to 4 rectangles, one per strip that it yields.
// When rect_o stalls, the pipeline keeps filling until every stage holds a
// run, then item_i.ready drops; nothing is lost or repeated.
// Reset clears all stage valids and pending strips and loads the default
// configuration: zero offset, unit scale, 4096 x 4096 framebuffer.
module scissor_clip_minus_hole_strips #(
  parameter int unsigned COORD_FRAC_BITS = 4,
  parameter int unsigned SCALE_FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scmh_pkg::PADDR_W-1:0]  paddr,
  input  logic [scmh_pkg::PDATA_W-1:0]  pwdata,
  output logic [scmh_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  scmh_chan_if.sink                     item_i,
  scmh_chan_if.source                   rect_o
);
  import scmh_pkg::*;

  cfg_t cfg;

  scmh_chan_if #(.payload_t(rects_t)) geom_ch ();

  scmh_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  scmh_geom #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .item_i  (item_i),
    .rects_o (geom_ch)
  );

  scmh_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rects_i (geom_ch),
    .rect_o  (rect_o)
  );

endmodule

// ===== bench/tb.sv =====
module tb;
  import scmh_pkg::*;

  localparam int FIX = 12;
  localparam longint ONE = 4096;
  localparam int STUCK_LIMIT = 3000;
  localparam int PHASE_ITEMS = 56;

  typedef struct {
    item_t it;
    bit    typed;
    int    n;
    out_t  r[4];
  } run_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic               pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;

  scmh_chan_if #(.payload_t(item_t)) item_if ();
  scmh_chan_if #(.payload_t(out_t))  rect_if ();

  scissor_clip_minus_hole_strips u_top (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .item_i (item_if),
    .rect_o (rect_if)
  );

  // shadow of the block's registers
  longint cfg_off_x, cfg_off_y, cfg_sx, cfg_sy, cfg_fb_w, cfg_fb_h;

  out_t     strips_due[$];
  run_row_t runs_sent[$];
  run_row_t dir_tbl[$];
  int       mismatches = 0;
  int       stuck_cycles = 0;
  int       hold_len = 0;
  bit       quiet = 0;

  int cfg_plan[6][6] = '{
    '{100, -50, 512, 128, 1920, 1080},
    '{-4096, 4095, 65535, 65535, 4096, 4096},
    '{4095, -4096, 0, 0, 0, 0},
    '{0, 0, 1, 1, 8191, 8191},
    '{-300, 200, 300, 700, 640, 480},
    '{12, 7, 256, 256, 8191, 1}
  };
  int hold_plan[6] = '{0, 0, 0, 0, 400, 0};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint lmax(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint lmin(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] to_px(longint v);
    if (v < 0) v = 0;
    return PIX_W'(v >> FIX);
  endfunction

  function automatic out_t mk_strip(longint l, longint t, longint r, longint b, logic sc);
    out_t o;
    o.rect_x     = to_px(l);
    o.rect_y     = to_px(t);
    o.rect_w     = to_px(r - l);
    o.rect_h     = to_px(b - t);
    o.scissor_on = sc;
    o.last       = 1'b0;
    return o;
  endfunction

  function automatic void predict_strips(item_t it);
    longint ox, oy, x0, y0, x1, y1, hx0, hy0, hx1, hy1, t, b, l, r;
    logic   sc;
    out_t   strips[$];
    ox = cfg_off_x * ONE;
    oy = cfg_off_y * ONE;
    x0 = 0;
    y0 = 0;
    x1 = cfg_fb_w * ONE;
    y1 = cfg_fb_h * ONE;
    sc = it.clip_on | it.hole_on;
    if (it.clip_on) begin
      x0 = lmax(ox + longint'($signed(it.clip_x)) * cfg_sx, 0);
      y0 = lmax(oy + longint'($signed(it.clip_y)) * cfg_sy, 0);
      x1 = lmin(ox + (longint'($signed(it.clip_x)) + longint'(it.clip_w)) * cfg_sx, x1);
      y1 = lmin(oy + (longint'($signed(it.clip_y)) + longint'(it.clip_h)) * cfg_sy, y1);
      if (x1 <= x0 || y1 <= y0) return;
    end
    if (!it.hole_on) begin
      strips = {strips, mk_strip(x0, y0, x1, y1, sc)};
    end else begin
      hx0 = ox + longint'($signed(it.hole_x)) * cfg_sx;
      hy0 = oy + longint'($signed(it.hole_y)) * cfg_sy;
      hx1 = hx0 + longint'(it.hole_w) * cfg_sx;
      hy1 = hy0 + longint'(it.hole_h) * cfg_sy;
      t = lmin(hy0, y1);
      if (t > y0) strips = {strips, mk_strip(x0, y0, x1, t, sc)};
      b = lmax(hy1, y0);
      if (y1 > b) strips = {strips, mk_strip(x0, b, x1, y1, sc)};
      t = lmax(hy0, y0);
      b = lmin(hy1, y1);
      if (b > t) begin
        l = lmin(hx0, x1);
        if (l > x0) strips = {strips, mk_strip(x0, t, l, b, sc)};
        r = lmax(hx1, x0);
        if (x1 > r) strips = {strips, mk_strip(r, t, x1, b, sc)};
      end
    end
    if (strips.size() > 0) strips[$].last = 1'b1;
    foreach (strips[k]) strips_due = {strips_due, strips[k]};
  endfunction

  function automatic item_t mk_item(bit con, int cx, int cy, int cw, int ch,
                                    bit hon, int hx, int hy, int hw, int hh);
    item_t it;
    it.clip_on = con;
    it.clip_x  = 16'(cx);
    it.clip_y  = 16'(cy);
    it.clip_w  = 16'(cw);
    it.clip_h  = 16'(ch);
    it.hole_on = hon;
    it.hole_x  = 16'(hx);
    it.hole_y  = 16'(hy);
    it.hole_w  = 16'(hw);
    it.hole_h  = 16'(hh);
    return it;
  endfunction

  function automatic out_t mk_rect(int x, int y, int w, int h, bit sc, bit lst);
    out_t o;
    o.rect_x     = PIX_W'(x);
    o.rect_y     = PIX_W'(y);
    o.rect_w     = PIX_W'(w);
    o.rect_h     = PIX_W'(h);
    o.scissor_on = sc;
    o.last       = lst;
    return o;
  endfunction

  function automatic run_row_t mk_run(item_t it, bit typed = 0, int n = 0, out_t r0 = '0,
                                      out_t r1 = '0, out_t r2 = '0, out_t r3 = '0);
    run_row_t row;
    row.it    = it;
    row.typed = typed;
    row.n     = n;
    row.r[0]  = r0;
    row.r[1]  = r1;
    row.r[2]  = r2;
    row.r[3]  = r3;
    return row;
  endfunction

  function automatic void add_row(run_row_t row);
    dir_tbl = {dir_tbl, row};
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return lmin(lmax(v, lo), hi);
  endfunction

  // places clip and hole along one axis so that they land on the framebuffer
  function automatic void fill_axis(input longint off, input longint sc, input longint fb,
                                    output logic [15:0] cp, output logic [15:0] cl,
                                    output logic [15:0] hp, output logic [15:0] hl);
    longint span, base, p, w, q, v;
    span = (sc == 0) ? 4096 : (lmax(fb, 1) * 4096) / sc;
    span = clampl(span, 8, 40000);
    base = (sc == 0) ? 0 : -(off * 4096) / sc;
    p = clampl(base - span / 8 + longint'($urandom_range(0, int'(span))), -32768, 32767);
    w = longint'($urandom_range(0, int'(span)));
    q = p - span / 8 + longint'($urandom_range(0, int'(w + span / 4)));
    v = longint'($urandom_range(0, int'(span / 2)));
    cp = 16'(p);
    cl = 16'(clampl(w, 0, 65535));
    hp = 16'(clampl(q, -32768, 32767));
    hl = 16'(v);
  endfunction

  function automatic item_t rand_item();
    logic [159:0] raw;
    item_t        it;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    it = raw[$bits(item_t)-1:0];
    if ($urandom_range(0, 9) < 2) return it;
    it.clip_on = ($urandom_range(0, 9) < 8);
    it.hole_on = ($urandom_range(0, 9) < 7);
    fill_axis(cfg_off_x, cfg_sx, cfg_fb_w, it.clip_x, it.clip_w, it.hole_x, it.hole_w);
    fill_axis(cfg_off_y, cfg_sy, cfg_fb_h, it.clip_y, it.clip_h, it.hole_y, it.hole_h);
    return it;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_OFFSET_X:  cfg_off_x = longint'($signed(val[PIX_W-1:0]));
      REG_OFFSET_Y:  cfg_off_y = longint'($signed(val[PIX_W-1:0]));
      REG_SCALE_X:   cfg_sx    = longint'(val[SCL_W-1:0]);
      REG_SCALE_Y:   cfg_sy    = longint'(val[SCL_W-1:0]);
      REG_FB_WIDTH:  cfg_fb_w  = longint'(val[PIX_W-1:0]);
      REG_FB_HEIGHT: cfg_fb_h  = longint'(val[PIX_W-1:0]);
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_run(run_row_t row);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    runs_sent = {runs_sent, row};
    item_if.valid   <= 1'b1;
    item_if.payload <= row.it;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
  endtask

  task automatic run_phase(int n_items, int hold);
    hold_len = hold;
    for (int i = 0; i < n_items; i++) begin
      quiet = ((i / 14) % 4) == 3;
      send_run(mk_run(rand_item()));
    end
    quiet = 0;
    item_if.valid <= 1'b0;
  endtask

  task automatic settle();
    while (strips_due.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // predict at each item transfer
  always @(posedge clk_i) begin
    run_row_t row;
    if (rst_ni && item_if.valid && item_if.ready) begin
      row = runs_sent.pop_front();
      if (row.typed) begin
        for (int k = 0; k < row.n; k++) strips_due = {strips_due, row.r[k]};
      end else begin
        predict_strips(item_if.payload);
      end
    end
  end

  // compare each rectangle transfer
  always @(posedge clk_i) begin
    out_t want, got;
    if (rst_ni && rect_if.valid && rect_if.ready) begin
      got = rect_if.payload;
      if (strips_due.size() == 0) begin
        $display("%0t: unexpected rectangle, expected none, got x=%0d y=%0d w=%0d h=%0d",
                 $time, got.rect_x, got.rect_y, got.rect_w, got.rect_h);
        mismatches++;
      end else begin
        want = strips_due.pop_front();
        check_field("rect_x", want.rect_x, got.rect_x);
        check_field("rect_y", want.rect_y, got.rect_y);
        check_field("rect_w", want.rect_w, got.rect_w);
        check_field("rect_h", want.rect_h, got.rect_h);
        check_field("scissor_on", want.scissor_on, got.scissor_on);
        check_field("last", want.last, got.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) || (rect_if.valid && rect_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // rectangle receiver
  initial begin
    int stall;
    rect_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_len > 0) begin
        rect_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end
      stall = quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        rect_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rect_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rect_if.valid) @(posedge clk_i);
    end
  end

  initial begin
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    item_if.valid   <= 1'b0;
    item_if.payload <= '0;
    rst_ni          <= 1'b0;
    cfg_off_x = 0;
    cfg_off_y = 0;
    cfg_sx    = 256;
    cfg_sy    = 256;
    cfg_fb_w  = 4096;
    cfg_fb_h  = 4096;

    // no clip and no hole, fields ignored; then a plain clip
    add_row(mk_run(mk_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                   1, 1, mk_rect(0, 0, 4096, 4096, 0, 1)));
    add_row(mk_run(mk_item(0, -1, -1, 65535, 65535, 0, -1, -1, 65535, 65535),
                   1, 1, mk_rect(0, 0, 4096, 4096, 0, 1)));
    add_row(mk_run(mk_item(1, 0, 0, 160, 160, 0, 0, 0, 0, 0),
                   1, 1, mk_rect(0, 0, 10, 10, 1, 1)));
    // empty clip
    add_row(mk_run(mk_item(1, 160, 160, 0, 320, 0, 0, 0, 0, 0), 1, 0));
    add_row(mk_run(mk_item(1, 160, 160, 320, 0, 0, 0, 0, 0, 0), 1, 0));
    add_row(mk_run(mk_item(1, -32768, -32768, 0, 0, 0, 0, 0, 0, 0), 1, 0));
    // hole covers all
    add_row(mk_run(mk_item(1, 0, 0, 160, 160, 1, -16, -16, 320, 320), 1, 0));
    // hole in the middle, all four strips; then huge clips, no hole
    add_row(mk_run(mk_item(1, 0, 0, 1600, 1600, 1, 160, 160, 320, 320), 1, 4,
                   mk_rect(0, 0, 100, 10, 1, 0), mk_rect(0, 30, 100, 70, 1, 0),
                   mk_rect(0, 10, 10, 20, 1, 0), mk_rect(30, 10, 70, 20, 1, 1)));
    add_row(mk_run(mk_item(1, -32768, -32768, 65535, 65535, 0, 0, 0, 0, 0)));
    add_row(mk_run(mk_item(1, 32767, 32767, 65535, 65535, 0, 0, 0, 0, 0)));
    // hole only, clip area is the framebuffer; then one clip with a hole
    add_row(mk_run(mk_item(0, 0, 0, 0, 0, 1, 800, 800, 1600, 1600)));
    add_row(mk_run(mk_item(0, 0, 0, 0, 0, 1, -32768, -32768, 65535, 65535)));
    add_row(mk_run(mk_item(0, 0, 0, 0, 0, 1, 32767, 32767, 65535, 65535)));
    add_row(mk_run(mk_item(1, 0, 0, 1600, 1600, 1, 1200, 400, 800, 400)));
    // hole above the clip, no middle columns; then flat or wide holes
    add_row(mk_run(mk_item(1, 0, 800, 1600, 1600, 1, 0, 0, 1600, 400)));
    add_row(mk_run(mk_item(1, 0, 0, 1600, 1600, 1, 160, 800, 320, 0)));
    add_row(mk_run(mk_item(1, 160, 160, 1600, 1600, 1, 0, 480, 32767, 320)));
    add_row(mk_run(mk_item(1, 160, 160, 1600, 1600, 1, -800, 480, 1200, 320)));
    add_row(mk_run(mk_item(1, 100, 100, 3000, 3000, 1, -32768, 200, 65535, 65535)));
    // fractional edges, truncation
    add_row(mk_run(mk_item(1, 5, 7, 1603, 1599, 1, 163, 171, 317, 333)));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) send_run(dir_tbl[i]);
    run_phase(PHASE_ITEMS, 0);

    for (int p = 0; p < 6; p++) begin
      settle();
      write_reg(REG_OFFSET_X, PDATA_W'(cfg_plan[p][0]));
      write_reg(REG_OFFSET_Y, PDATA_W'(cfg_plan[p][1]));
      write_reg(REG_SCALE_X, PDATA_W'(cfg_plan[p][2]));
      write_reg(REG_SCALE_Y, PDATA_W'(cfg_plan[p][3]));
      write_reg(REG_FB_WIDTH, PDATA_W'(cfg_plan[p][4]));
      write_reg(REG_FB_HEIGHT, PDATA_W'(cfg_plan[p][5]));
      run_phase(PHASE_ITEMS, hold_plan[p]);
    end

    while (strips_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== scissor_clip_minus_hole_strips.f =====
hdl/scmh_pkg.sv
hdl/scmh_chan_if.sv
hdl/scmh_cfg_regs.sv
hdl/scmh_geom.sv
hdl/scmh_emit.sv
hdl/scissor_clip_minus_hole_strips.sv
bench/tb.sv
